@@ hdl/csfc_pkg.sv @@
// Package: request/result types, microcode format, program ROM and helper functions.
package csfc_pkg;

  typedef struct packed {
    logic        req_type;
    logic [15:0] peer_mtu;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [1:0] frame_kind;
    logic       frame_last;
    logic       last;
  } res_t;

  localparam logic        REQ_START = 1'b0;
  localparam logic        REQ_BYTE  = 1'b1;

  localparam logic [1:0]  KIND_HDR  = 2'd0;
  localparam logic [1:0]  KIND_DATA = 2'd1;
  localparam logic [1:0]  KIND_END  = 2'd2;
  localparam logic [1:0]  KIND_ERR  = 2'd3;

  localparam logic [7:0]  TAG_HDR   = 8'h01;
  localparam logic [7:0]  TAG_DATA  = 8'h02;
  localparam logic [7:0]  TAG_END   = 8'h03;
  localparam logic [7:0]  TAG_ERR   = 8'h7F;

  localparam logic [15:0] MTU_MIN   = 16'd23;
  localparam logic [15:0] CHUNK_OVH = 16'd6;
  localparam logic [15:0] MAX_CHUNK = 16'd240;
  localparam logic [15:0] MIN_CHUNK = 16'd16;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;

  localparam int          DVD_W     = 33;
  localparam int          DCNT_W    = 6;

  localparam int          IDX_W     = 5;
  localparam logic [IDX_W-1:0] ERR_LAST = 5'd16;

  // byte sources
  localparam logic [3:0] SRC_CONST  = 4'd0;
  localparam logic [3:0] SRC_CNT_HI = 4'd1;
  localparam logic [3:0] SRC_CNT_LO = 4'd2;
  localparam logic [3:0] SRC_LEN3   = 4'd3;
  localparam logic [3:0] SRC_LEN2   = 4'd4;
  localparam logic [3:0] SRC_LEN1   = 4'd5;
  localparam logic [3:0] SRC_LEN0   = 4'd6;
  localparam logic [3:0] SRC_SEQ_HI = 4'd7;
  localparam logic [3:0] SRC_SEQ_LO = 4'd8;
  localparam logic [3:0] SRC_PB     = 4'd9;
  localparam logic [3:0] SRC_CRC3   = 4'd10;
  localparam logic [3:0] SRC_CRC2   = 4'd11;
  localparam logic [3:0] SRC_CRC1   = 4'd12;
  localparam logic [3:0] SRC_CRC0   = 4'd13;
  localparam logic [3:0] SRC_ERR    = 4'd14;

  // frame_last modes
  localparam logic [1:0] FL_0    = 2'd0;
  localparam logic [1:0] FL_1    = 2'd1;
  localparam logic [1:0] FL_DATA = 2'd2;
  localparam logic [1:0] FL_IDX  = 2'd3;

  // last modes
  localparam logic [2:0] LS_0     = 3'd0;
  localparam logic [2:0] LS_1     = 3'd1;
  localparam logic [2:0] LS_LENNZ = 3'd2;
  localparam logic [2:0] LS_NSEND = 3'd3;
  localparam logic [2:0] LS_IDX   = 3'd4;

  // datapath actions
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_SETUP   = 3'd1;
  localparam logic [2:0] ACT_COMMIT  = 3'd2;
  localparam logic [2:0] ACT_BYTE    = 3'd3;
  localparam logic [2:0] ACT_IDX_CLR = 3'd4;
  localparam logic [2:0] ACT_IDX_INC = 3'd5;

  // jump conditions
  localparam logic [2:0] C_NONE  = 3'd0;
  localparam logic [2:0] C_ALW   = 3'd1;
  localparam logic [2:0] C_BUSY  = 3'd2;
  localparam logic [2:0] C_OVF   = 3'd3;
  localparam logic [2:0] C_LENNZ = 3'd4;
  localparam logic [2:0] C_IDXNE = 3'd5;
  localparam logic [2:0] C_NSEND = 3'd6;

  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] PC_START = 5'd1;
  localparam logic [PC_W-1:0] PC_DIVW  = 5'd2;
  localparam logic [PC_W-1:0] PC_OVCHK = 5'd3;
  localparam logic [PC_W-1:0] PC_HDR0  = 5'd4;
  localparam logic [PC_W-1:0] PC_HDR1  = 5'd5;
  localparam logic [PC_W-1:0] PC_HDR2  = 5'd6;
  localparam logic [PC_W-1:0] PC_HDR3  = 5'd7;
  localparam logic [PC_W-1:0] PC_HDR4  = 5'd8;
  localparam logic [PC_W-1:0] PC_HDR5  = 5'd9;
  localparam logic [PC_W-1:0] PC_HDR6  = 5'd10;
  localparam logic [PC_W-1:0] PC_END0  = 5'd11;
  localparam logic [PC_W-1:0] PC_END1  = 5'd12;
  localparam logic [PC_W-1:0] PC_END2  = 5'd13;
  localparam logic [PC_W-1:0] PC_END3  = 5'd14;
  localparam logic [PC_W-1:0] PC_END4  = 5'd15;
  localparam logic [PC_W-1:0] PC_ERR0  = 5'd16;
  localparam logic [PC_W-1:0] PC_ERRT  = 5'd17;
  localparam logic [PC_W-1:0] PC_ERRX  = 5'd18;
  localparam logic [PC_W-1:0] PC_DPRE0 = 5'd19;
  localparam logic [PC_W-1:0] PC_DPRE1 = 5'd20;
  localparam logic [PC_W-1:0] PC_DPRE2 = 5'd21;
  localparam logic [PC_W-1:0] PC_DBYTE = 5'd22;
  localparam logic [PC_W-1:0] PC_DEND  = 5'd23;

  typedef struct packed {
    logic            emit;
    logic [3:0]      src;
    logic [7:0]      cval;
    logic [1:0]      kind;
    logic [1:0]      fl;
    logic [2:0]      ls;
    logic [2:0]      act;
    logic [2:0]      cond;
    logic [PC_W-1:0] tgt;
  } ucw_t;

  function automatic ucw_t mk(input logic emit, input logic [3:0] src, input logic [7:0] cval,
                              input logic [1:0] kind, input logic [1:0] fl,
                              input logic [2:0] ls, input logic [2:0] act,
                              input logic [2:0] cond, input logic [PC_W-1:0] tgt);
    ucw_t w;
    w.emit = emit;
    w.src  = src;
    w.cval = cval;
    w.kind = kind;
    w.fl   = fl;
    w.ls   = ls;
    w.act  = act;
    w.cond = cond;
    w.tgt  = tgt;
    return w;
  endfunction

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      PC_IDLE:  w = mk(1'b0, SRC_CONST, 8'd0, KIND_HDR, FL_0, LS_0, ACT_NONE, C_ALW, PC_IDLE);
      PC_START: w = mk(1'b0, SRC_CONST, 8'd0, KIND_HDR, FL_0, LS_0, ACT_SETUP, C_NONE, PC_IDLE);
      PC_DIVW:  w = mk(1'b0, SRC_CONST, 8'd0, KIND_HDR, FL_0, LS_0, ACT_NONE, C_BUSY, PC_DIVW);
      PC_OVCHK: w = mk(1'b0, SRC_CONST, 8'd0, KIND_HDR, FL_0, LS_0, ACT_NONE, C_OVF, PC_ERR0);
      PC_HDR0:  w = mk(1'b1, SRC_CONST, TAG_HDR, KIND_HDR, FL_0, LS_0, ACT_COMMIT, C_NONE,
                       PC_IDLE);
      PC_HDR1:  w = mk(1'b1, SRC_CNT_HI, 8'd0, KIND_HDR, FL_0, LS_0, ACT_NONE, C_NONE, PC_IDLE);
      PC_HDR2:  w = mk(1'b1, SRC_CNT_LO, 8'd0, KIND_HDR, FL_0, LS_0, ACT_NONE, C_NONE, PC_IDLE);
      PC_HDR3:  w = mk(1'b1, SRC_LEN3, 8'd0, KIND_HDR, FL_0, LS_0, ACT_NONE, C_NONE, PC_IDLE);
      PC_HDR4:  w = mk(1'b1, SRC_LEN2, 8'd0, KIND_HDR, FL_0, LS_0, ACT_NONE, C_NONE, PC_IDLE);
      PC_HDR5:  w = mk(1'b1, SRC_LEN1, 8'd0, KIND_HDR, FL_0, LS_0, ACT_NONE, C_NONE, PC_IDLE);
      PC_HDR6:  w = mk(1'b1, SRC_LEN0, 8'd0, KIND_HDR, FL_1, LS_LENNZ, ACT_NONE, C_LENNZ,
                       PC_IDLE);
      PC_END0:  w = mk(1'b1, SRC_CONST, TAG_END, KIND_END, FL_0, LS_0, ACT_NONE, C_NONE,
                       PC_IDLE);
      PC_END1:  w = mk(1'b1, SRC_CRC3, 8'd0, KIND_END, FL_0, LS_0, ACT_NONE, C_NONE, PC_IDLE);
      PC_END2:  w = mk(1'b1, SRC_CRC2, 8'd0, KIND_END, FL_0, LS_0, ACT_NONE, C_NONE, PC_IDLE);
      PC_END3:  w = mk(1'b1, SRC_CRC1, 8'd0, KIND_END, FL_0, LS_0, ACT_NONE, C_NONE, PC_IDLE);
      PC_END4:  w = mk(1'b1, SRC_CRC0, 8'd0, KIND_END, FL_1, LS_1, ACT_NONE, C_ALW, PC_IDLE);
      PC_ERR0:  w = mk(1'b1, SRC_CONST, TAG_ERR, KIND_ERR, FL_0, LS_0, ACT_IDX_CLR, C_NONE,
                       PC_IDLE);
      PC_ERRT:  w = mk(1'b1, SRC_ERR, 8'd0, KIND_ERR, FL_IDX, LS_IDX, ACT_IDX_INC, C_IDXNE,
                       PC_ERRT);
      PC_ERRX:  w = mk(1'b0, SRC_CONST, 8'd0, KIND_ERR, FL_0, LS_0, ACT_NONE, C_ALW, PC_IDLE);
      PC_DPRE0: w = mk(1'b1, SRC_CONST, TAG_DATA, KIND_DATA, FL_0, LS_0, ACT_NONE, C_NONE,
                       PC_IDLE);
      PC_DPRE1: w = mk(1'b1, SRC_SEQ_HI, 8'd0, KIND_DATA, FL_0, LS_0, ACT_NONE, C_NONE,
                       PC_IDLE);
      PC_DPRE2: w = mk(1'b1, SRC_SEQ_LO, 8'd0, KIND_DATA, FL_0, LS_0, ACT_NONE, C_NONE,
                       PC_IDLE);
      PC_DBYTE: w = mk(1'b1, SRC_PB, 8'd0, KIND_DATA, FL_DATA, LS_NSEND, ACT_BYTE, C_NSEND,
                       PC_IDLE);
      PC_DEND:  w = mk(1'b0, SRC_CONST, 8'd0, KIND_DATA, FL_0, LS_0, ACT_NONE, C_ALW, PC_END0);
      default:  w = mk(1'b0, SRC_CONST, 8'd0, KIND_HDR, FL_0, LS_0, ACT_NONE, C_ALW, PC_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] err_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = 8'h70;
      5'd1:    c = 8'h61;
      5'd2:    c = 8'h79;
      5'd3:    c = 8'h6C;
      5'd4:    c = 8'h6F;
      5'd5:    c = 8'h61;
      5'd6:    c = 8'h64;
      5'd7:    c = 8'h20;
      5'd8:    c = 8'h74;
      5'd9:    c = 8'h6F;
      5'd10:   c = 8'h6F;
      5'd11:   c = 8'h20;
      5'd12:   c = 8'h6C;
      5'd13:   c = 8'h61;
      5'd14:   c = 8'h72;
      5'd15:   c = 8'h67;
      5'd16:   c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hdl/chunked_stream_framer_crc32.sv @@
// Top level: microcoded framer that turns start and byte requests into frame bytes.
//
// Input channel in_valid/in_stall/in_data carries one request: a start request
// (peer MTU and payload length) or one payload byte. Output channel
// out_valid/out_stall/out_data carries one frame byte per transfer, tagged with
// its frame kind, end-of-frame flag and a last flag on the final byte a
// request causes. Requests that cause nothing (start while a stream runs,
// byte while none runs) are taken without leaving the idle step.
// A start request runs the bit-serial chunk-count divider and then sends the
// 7-byte header and, for an empty payload, the END frame; on chunk-count
// overflow it sends the error frame instead. A payload byte inside a chunk
// sends its data byte, the first byte of a chunk comes after the DATA prefix,
// and the last byte of the stream is followed by the END frame. The output
// register passes one frame byte per cycle while the receiver does not stall.
// in_stall is high while a request is being worked on. When the receiver
// stalls, the sequencer holds on its current output step and the registered
// byte stays on out_data. Reset clears the stream state and empties the
// output register.
module chunked_stream_framer_crc32 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  csfc_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output csfc_pkg::res_t out_data
);
  import csfc_pkg::*;

  logic [PC_W-1:0]  pc_r, pc_nxt;
  ucw_t             uw;
  req_t             req_r;
  logic             active_r;
  logic [31:0]      total_len_r;
  logic [31:0]      seen_r;
  logic [7:0]       chunk_r;
  logic [7:0]       pos_r;
  logic [15:0]      seq_r;
  logic [31:0]      crc_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  res_t             out_r;

  logic             in_acc, out_free, fire, step_go, emit_go, cond_hit;
  logic [15:0]      mtu_lo, mtu_cs;
  logic [7:0]       cs_w;
  logic [8:0]       pos_inc;
  logic [32:0]      seen_inc;
  logic             chunk_end, stream_end;
  logic [7:0]       byte_w;
  logic             flast_w, last_w;
  logic [31:0]      crc_out;
  logic             div_busy, div_ovf, div_start;
  logic [15:0]      div_q;
  logic [DVD_W-1:0] div_dvd;

  assign uw       = ucode(pc_r);
  assign in_stall = (pc_r != PC_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = !uw.emit || out_free;
  assign step_go  = (pc_r != PC_IDLE) && fire;
  assign emit_go  = step_go && uw.emit;

  assign mtu_lo  = (req_r.peer_mtu < MTU_MIN) ? MTU_MIN : req_r.peer_mtu;
  assign mtu_cs  = mtu_lo - CHUNK_OVH;
  always_comb begin
    priority if (mtu_cs > MAX_CHUNK) cs_w = MAX_CHUNK[7:0];
    else if (mtu_cs < MIN_CHUNK) cs_w = MIN_CHUNK[7:0];
    else cs_w = mtu_cs[7:0];
  end

  assign div_dvd   = {1'b0, req_r.payload_length} + {25'd0, cs_w} - DVD_W'(1);
  assign div_start = step_go && (uw.act == ACT_SETUP);

  csfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (cs_w),
    .busy     (div_busy),
    .quot     (div_q),
    .ovf      (div_ovf)
  );

  assign pos_inc    = {1'b0, pos_r} + 9'd1;
  assign chunk_end  = pos_inc >= {1'b0, chunk_r};
  assign seen_inc   = {1'b0, seen_r} + 33'd1;
  assign stream_end = seen_inc >= {1'b0, total_len_r};
  assign crc_out    = ~crc_r;

  always_comb begin
    unique case (uw.cond)
      C_NONE:  cond_hit = 1'b0;
      C_ALW:   cond_hit = 1'b1;
      C_BUSY:  cond_hit = div_busy;
      C_OVF:   cond_hit = div_ovf;
      C_LENNZ: cond_hit = (total_len_r != 32'd0);
      C_IDXNE: cond_hit = (idx_r != ERR_LAST);
      C_NSEND: cond_hit = !stream_end;
      default: cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (pc_r == PC_IDLE) begin
      if (in_acc) begin
        priority if (in_data.req_type == REQ_START && !active_r) pc_nxt = PC_START;
        else if (in_data.req_type == REQ_BYTE && active_r && pos_r == 8'd0) pc_nxt = PC_DPRE0;
        else if (in_data.req_type == REQ_BYTE && active_r) pc_nxt = PC_DBYTE;
        else pc_nxt = PC_IDLE;
      end
    end else if (fire) begin
      pc_nxt = cond_hit ? uw.tgt : pc_r + PC_W'(1);
    end
  end

  always_comb begin
    unique case (uw.src)
      SRC_CNT_HI: byte_w = div_q[15:8];
      SRC_CNT_LO: byte_w = div_q[7:0];
      SRC_LEN3:   byte_w = total_len_r[31:24];
      SRC_LEN2:   byte_w = total_len_r[23:16];
      SRC_LEN1:   byte_w = total_len_r[15:8];
      SRC_LEN0:   byte_w = total_len_r[7:0];
      SRC_SEQ_HI: byte_w = seq_r[15:8];
      SRC_SEQ_LO: byte_w = seq_r[7:0];
      SRC_PB:     byte_w = req_r.payload_byte;
      SRC_CRC3:   byte_w = crc_out[31:24];
      SRC_CRC2:   byte_w = crc_out[23:16];
      SRC_CRC1:   byte_w = crc_out[15:8];
      SRC_CRC0:   byte_w = crc_out[7:0];
      SRC_ERR:    byte_w = err_char(idx_r);
      default:    byte_w = uw.cval;
    endcase
  end

  always_comb begin
    unique case (uw.fl)
      FL_0:    flast_w = 1'b0;
      FL_1:    flast_w = 1'b1;
      FL_DATA: flast_w = chunk_end || stream_end;
      FL_IDX:  flast_w = (idx_r == ERR_LAST);
    endcase
  end

  always_comb begin
    unique case (uw.ls)
      LS_0:     last_w = 1'b0;
      LS_1:     last_w = 1'b1;
      LS_LENNZ: last_w = (total_len_r != 32'd0);
      LS_NSEND: last_w = !stream_end;
      LS_IDX:   last_w = (idx_r == ERR_LAST);
      default:  last_w = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      active_r    <= 1'b0;
      total_len_r <= '0;
      seen_r      <= '0;
      chunk_r     <= MIN_CHUNK[7:0];
      pos_r       <= '0;
      seq_r       <= '0;
      crc_r       <= '1;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (step_go) begin
        unique case (uw.act)
          ACT_SETUP: begin
            chunk_r     <= cs_w;
            total_len_r <= req_r.payload_length;
          end
          ACT_COMMIT: begin
            seen_r   <= '0;
            pos_r    <= '0;
            seq_r    <= '0;
            crc_r    <= '1;
            active_r <= (total_len_r != 32'd0);
          end
          ACT_BYTE: begin
            crc_r  <= crc_byte(crc_r, req_r.payload_byte);
            seen_r <= seen_inc[31:0];
            if (chunk_end) begin
              pos_r <= '0;
              seq_r <= seq_r + 16'd1;
            end else begin
              pos_r <= pos_inc[7:0];
            end
            if (stream_end) begin
              active_r <= 1'b0;
            end
          end
          ACT_IDX_CLR: idx_r <= '0;
          ACT_IDX_INC: idx_r <= idx_r + IDX_W'(1);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data;
    end
    if (emit_go) begin
      out_r.frame_byte <= byte_w;
      out_r.frame_kind <= uw.kind;
      out_r.frame_last <= flast_w;
      out_r.last       <= last_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hdl/csfc_div.sv @@
// Bit-serial restoring divider for the chunk count, with overflow above 16 bits.
module csfc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [csfc_pkg::DVD_W-1:0] dividend,
  input  logic [7:0]                 divisor,
  output logic                       busy,
  output logic [15:0]                quot,
  output logic                       ovf
);
  import csfc_pkg::*;

  logic              busy_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [7:0]        dsr_r;
  logic [7:0]        rem_r;
  logic [15:0]       q_r;
  logic              ovf_r;
  logic [8:0]        rem_sh;
  logic [8:0]        rem_df;
  logic              take;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign rem_df = rem_sh - {1'b0, dsr_r};
  assign take   = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DCNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= take ? rem_df[7:0] : rem_sh[7:0];
      q_r   <= {q_r[14:0], take};
      ovf_r <= ovf_r | q_r[15];
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign ovf  = ovf_r;

endmodule

@@ hdl/csfc_chk.sv @@
// Port checker for the framer, bound to the top level.
module csfc_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input csfc_pkg::res_t out_data
);
  import csfc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last && out_data.frame_kind != KIND_DATA |-> out_data.frame_last)
    else $error("last result not at end of a frame");

  a_err_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_kind == KIND_ERR && out_data.frame_last |-> out_data.last)
    else $error("error frame end not last result of request");

endmodule

bind chunked_stream_framer_crc32 csfc_chk u_chk (.*);

@@ tb/tb_top.sv @@
// Testbench for the chunked stream framer: directed table, random streams, frame-byte checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csfc_pkg::*;

  localparam int ITEM_TARGET    = 460;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 60;
  localparam int N_DIR          = 18;

  localparam logic [8*17-1:0] ERR_TEXT = "payload too large";

  localparam logic [7:0] EMPTY_FRAME [12] = '{
    8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h03, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_NONE,
    EXP_ERROR,
    EXP_EMPTY
  } exp_src_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_BLOCK
  } stall_mode_e;

  typedef struct packed {
    logic        op;
    logic [15:0] mtu;
    logic [31:0] len;
    logic [7:0]  pbyte;
    exp_src_e    src;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{REQ_BYTE,  16'hFFFF, 32'hFFFF_FFFF, 8'hA5, EXP_NONE},
    '{REQ_START, 16'h0000, 32'hFFFF_FFFF, 8'hFF, EXP_ERROR},
    '{REQ_START, 16'h0000, 32'd1114096,   8'h00, EXP_ERROR},
    '{REQ_START, 16'd246,  32'd15728401,  8'h5A, EXP_ERROR},
    '{REQ_BYTE,  16'h1234, 32'h0000_0000, 8'h00, EXP_NONE},
    '{REQ_START, 16'hFFFF, 32'h0000_0000, 8'hFF, EXP_EMPTY},
    '{REQ_START, 16'h0000, 32'h0000_0000, 8'h00, EXP_EMPTY},
    '{REQ_START, 16'd23,   32'd3,         8'h3C, EXP_MODEL},
    '{REQ_BYTE,  16'h0000, 32'h0000_0000, 8'h00, EXP_MODEL},
    '{REQ_BYTE,  16'hFFFF, 32'hFFFF_FFFF, 8'hFF, EXP_MODEL},
    '{REQ_BYTE,  16'h00AA, 32'h5555_AAAA, 8'h5A, EXP_MODEL},
    '{REQ_BYTE,  16'h0000, 32'h0000_0001, 8'h11, EXP_NONE},
    '{REQ_START, 16'hFFFF, 32'd2,         8'h00, EXP_MODEL},
    '{REQ_START, 16'd5,    32'd7,         8'hEE, EXP_NONE},
    '{REQ_BYTE,  16'h8000, 32'h8000_0000, 8'h80, EXP_MODEL},
    '{REQ_BYTE,  16'h7FFF, 32'h7FFF_FFFF, 8'h7F, EXP_MODEL},
    '{REQ_START, 16'd245,  32'd1,         8'h99, EXP_MODEL},
    '{REQ_BYTE,  16'h0001, 32'h0000_0000, 8'hC3, EXP_MODEL}
  };

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data  = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;

  res_t pending_frames [$];
  res_t new_frames [$];
  res_t want_r;
  int   err_count   = 0;
  int   items_done  = 0;
  int   burst_left  = 0;
  int   idle_cycles = 0;
  int   stall_run   = 0;
  stall_mode_e stall_mode = STALL_NONE;

  logic        strm_active = 1'b0;
  logic [31:0] strm_total  = '0;
  logic [31:0] strm_seen   = '0;
  logic [7:0]  chunk_sz    = 8'd16;
  logic [7:0]  chunk_pos   = '0;
  logic [15:0] seq_no      = '0;
  logic [31:0] crc_acc     = '1;

  chunked_stream_framer_crc32 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic void add_frame_byte(input logic [7:0] b, input logic [1:0] k,
                                         input logic fl);
    res_t f;
    f.frame_byte = b;
    f.frame_kind = k;
    f.frame_last = fl;
    f.last       = 1'b0;
    new_frames.push_back(f);
  endfunction

  function automatic void add_error_frame();
    add_frame_byte(TAG_ERR, KIND_ERR, 1'b0);
    for (int i = 0; i < 17; i++) begin
      add_frame_byte(ERR_TEXT[8*(16-i) +: 8], KIND_ERR, i == 16);
    end
  endfunction

  function automatic void add_end_frame(input logic [31:0] crc);
    add_frame_byte(TAG_END, KIND_END, 1'b0);
    add_frame_byte(crc[31:24], KIND_END, 1'b0);
    add_frame_byte(crc[23:16], KIND_END, 1'b0);
    add_frame_byte(crc[15:8], KIND_END, 1'b0);
    add_frame_byte(crc[7:0], KIND_END, 1'b1);
  endfunction

  function automatic int predict_frames(input req_t r);
    logic [15:0] mtu_eff;
    logic [15:0] cs;
    logic [63:0] nchunks;
    logic        chunk_end;
    logic        stream_end;
    new_frames.delete();
    if (r.req_type == REQ_START) begin
      if (!strm_active) begin
        mtu_eff = (r.peer_mtu < MTU_MIN) ? MTU_MIN : r.peer_mtu;
        cs = mtu_eff - CHUNK_OVH;
        if (cs > MAX_CHUNK) cs = MAX_CHUNK;
        if (cs < MIN_CHUNK) cs = MIN_CHUNK;
        chunk_sz   = cs[7:0];
        strm_total = r.payload_length;
        nchunks = ({32'd0, r.payload_length} + {48'd0, cs} - 64'd1) / {48'd0, cs};
        if (nchunks > 64'hFFFF) begin
          add_error_frame();
        end else begin
          add_frame_byte(TAG_HDR, KIND_HDR, 1'b0);
          add_frame_byte(nchunks[15:8], KIND_HDR, 1'b0);
          add_frame_byte(nchunks[7:0], KIND_HDR, 1'b0);
          add_frame_byte(r.payload_length[31:24], KIND_HDR, 1'b0);
          add_frame_byte(r.payload_length[23:16], KIND_HDR, 1'b0);
          add_frame_byte(r.payload_length[15:8], KIND_HDR, 1'b0);
          add_frame_byte(r.payload_length[7:0], KIND_HDR, 1'b1);
          strm_seen = '0;
          chunk_pos = '0;
          seq_no    = '0;
          crc_acc   = '1;
          if (r.payload_length == 32'd0) begin
            add_end_frame(32'd0);
          end else begin
            strm_active = 1'b1;
          end
        end
      end
    end else if (strm_active) begin
      if (chunk_pos == 8'd0) begin
        add_frame_byte(TAG_DATA, KIND_DATA, 1'b0);
        add_frame_byte(seq_no[15:8], KIND_DATA, 1'b0);
        add_frame_byte(seq_no[7:0], KIND_DATA, 1'b0);
      end
      chunk_end  = ({1'b0, chunk_pos} + 9'd1) >= {1'b0, chunk_sz};
      stream_end = ({1'b0, strm_seen} + 33'd1) >= {1'b0, strm_total};
      add_frame_byte(r.payload_byte, KIND_DATA, chunk_end | stream_end);
      crc_acc   = crc32_update(crc_acc, r.payload_byte);
      strm_seen = strm_seen + 32'd1;
      if (chunk_end) begin
        chunk_pos = '0;
        seq_no    = seq_no + 16'd1;
      end else begin
        chunk_pos = chunk_pos + 8'd1;
      end
      if (stream_end) begin
        add_end_frame(~crc_acc);
        strm_active = 1'b0;
      end
    end
    return new_frames.size();
  endfunction

  function automatic req_t rand_req(input logic op);
    req_t r;
    r.req_type       = op;
    r.peer_mtu       = 16'($urandom);
    r.payload_length = $urandom;
    r.payload_byte   = 8'($urandom);
    return r;
  endfunction

  task automatic push_req(input req_t r, input exp_src_e src);
    int   n;
    res_t f;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = predict_frames(r);
    if (src != EXP_MODEL) begin
      new_frames.delete();
      case (src)
        EXP_ERROR: begin
          add_error_frame();
        end
        EXP_EMPTY: begin
          for (int i = 0; i < 12; i++) begin
            add_frame_byte(EMPTY_FRAME[i], (i < 7) ? KIND_HDR : KIND_END,
                           (i == 6) || (i == 11));
          end
        end
        default: begin
        end
      endcase
    end
    if (new_frames.size() > 0) begin
      f = new_frames.pop_back();
      f.last = 1'b1;
      new_frames.push_back(f);
    end
    foreach (new_frames[i]) pending_frames.push_back(new_frames[i]);
    items_done++;
  endtask

  task automatic sender_pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_run  = $urandom_range(5, 60);
    end else begin
      stall_run--;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= ((stall_run % 7) < 3);
      default:        out_stall <= (stall_run < 15);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h kind %0d",
                                  out_data.frame_byte, out_data.frame_kind));
      end else begin
        want_r = pending_frames.pop_front();
        if (out_data.frame_byte !== want_r.frame_byte)
          report_mismatch($sformatf("frame_byte got %02h want %02h",
                                    out_data.frame_byte, want_r.frame_byte));
        if (out_data.frame_kind !== want_r.frame_kind)
          report_mismatch($sformatf("frame_kind got %0d want %0d",
                                    out_data.frame_kind, want_r.frame_kind));
        if (out_data.frame_last !== want_r.frame_last)
          report_mismatch($sformatf("frame_last got %0b want %0b",
                                    out_data.frame_last, want_r.frame_last));
        if (out_data.last !== want_r.last)
          report_mismatch($sformatf("last got %0b want %0b", out_data.last, want_r.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request or result moved for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    req_t r;
    int   sel;
    int   len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      r.req_type       = DIR_ROWS[i].op;
      r.peer_mtu       = DIR_ROWS[i].mtu;
      r.payload_length = DIR_ROWS[i].len;
      r.payload_byte   = DIR_ROWS[i].pbyte;
      push_req(r, DIR_ROWS[i].src);
      sender_pace();
    end
    wait_drained();

    while (items_done < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        r = rand_req(REQ_START);
        if ($urandom_range(0, 1) == 0) begin
          r.payload_length = r.payload_length | 32'h8000_0000;
        end else begin
          r.peer_mtu       = 16'($urandom_range(0, 23));
          r.payload_length = 32'd1114096 + $urandom_range(0, 1000);
        end
        push_req(r, EXP_MODEL);
        sender_pace();
      end else if (sel < 12) begin
        push_req(rand_req(REQ_BYTE), EXP_MODEL);
        sender_pace();
      end else if (sel < 15) begin
        r = rand_req(REQ_START);
        r.payload_length = '0;
        push_req(r, EXP_MODEL);
        sender_pace();
      end else begin
        r = rand_req(REQ_START);
        if ($urandom_range(0, 3) != 0) r.peer_mtu = 16'($urandom_range(0, 45));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 50);
        r.payload_length = len;
        push_req(r, EXP_MODEL);
        sender_pace();
        for (int b = 0; b < len; b++) begin
          if ($urandom_range(0, 29) == 0) begin
            push_req(rand_req(REQ_START), EXP_MODEL);
            sender_pace();
          end
          push_req(rand_req(REQ_BYTE), EXP_MODEL);
          sender_pace();
        end
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_frames.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
